// File: rtl/core/pend_pkg.sv
package pend_pkg;

  localparam int FRAC_BITS    = 24;
  localparam int STAMP_FRAC   = 20;
  localparam int CORDIC_STEPS = 30;
  localparam int IT_W         = $clog2(CORDIC_STEPS);

  localparam int ZSH       = 30 - FRAC_BITS;
  localparam int Z_W       = 32 + ZSH;
  localparam int MAG_W     = (Z_W > 34) ? Z_W : 34;
  localparam int RED_STEPS = (FRAC_BITS < 29) ? 29 - FRAC_BITS : 1;
  localparam int RK_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int CZ_W      = 36;
  localparam int XY_W      = 34;

  localparam int MIN_SH = (FRAC_BITS < STAMP_FRAC) ? FRAC_BITS : STAMP_FRAC;
  localparam int ACC_W  = 66 - MIN_SH;

  localparam logic [63:0] TWO_PI_Q30      = 64'd6746518852;
  localparam logic [63:0] PI_Q30          = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_GRAV        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_INERTIA = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_TORQ  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TORQ_SEL    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLISH     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_RATE  = 4'd7;

  typedef struct packed {
    logic mul_en;
    logic neg;
    logic stamp_frac;
  } alu_ctl_t;

  function automatic logic [31:0] atan_q30(input logic [IT_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [MAG_W-1:0] red_const(input logic [RK_W-1:0] k);
    logic [63:0] v;
    v = TWO_PI_Q30 << k;
    return MAG_W'(v);
  endfunction

endpackage

// File: rtl/core/pend_cordic.sv
module pend_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] sin_val
);
  import pend_pkg::*;

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_RED   = 3'd1;
  localparam logic [2:0] C_FOLD1 = 3'd2;
  localparam logic [2:0] C_FOLD2 = 3'd3;
  localparam logic [2:0] C_ITER  = 3'd4;

  localparam logic signed [CZ_W-1:0] ZPI  = CZ_W'(PI_Q30);
  localparam logic signed [CZ_W-1:0] Z2PI = CZ_W'(TWO_PI_Q30);
  localparam logic signed [CZ_W-1:0] ZHP  = CZ_W'(HALF_PI_Q30);
  localparam logic signed [XY_W-1:0] XGAIN = XY_W'(CORDIC_GAIN_Q30);
  localparam logic [IT_W-1:0] LAST_IT = IT_W'(CORDIC_STEPS - 1);
  localparam logic [RK_W-1:0] TOP_K   = RK_W'(RED_STEPS - 1);

  logic [2:0]              state_r, state_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [RK_W-1:0]         k_r, k_nxt;
  logic [IT_W-1:0]         i_r, i_nxt;
  logic signed [CZ_W-1:0]  z_r, z_nxt;
  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic                    done_r, done_nxt;

  logic signed [Z_W-1:0]   z0;
  logic signed [Z_W-1:0]   z0_neg;
  logic [MAG_W-1:0]        rc;
  logic signed [CZ_W-1:0]  zm;
  logic signed [CZ_W-1:0]  zs;
  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [CZ_W-1:0]  at;

  always_comb begin
    z0     = Z_W'(angle) <<< ZSH;
    z0_neg = -z0;
    rc     = red_const(k_r);
    zm     = CZ_W'(mag_r);
    zs     = neg_r ? -zm : zm;
    dx     = y_r >>> i_r;
    dy     = x_r >>> i_r;
    at     = CZ_W'(atan_q30(i_r));

    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    z_nxt     = z_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    done_nxt  = 1'b0;

    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          neg_nxt   = z0[Z_W-1];
          mag_nxt   = z0[Z_W-1] ? MAG_W'($unsigned(z0_neg)) : MAG_W'($unsigned(z0));
          k_nxt     = TOP_K;
          state_nxt = C_RED;
        end
      end
      C_RED: begin
        if (mag_r >= rc) begin
          mag_nxt = mag_r - rc;
        end
        if (k_r == '0) begin
          state_nxt = C_FOLD1;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      C_FOLD1: begin
        if (zs > ZPI) begin
          z_nxt = zs - Z2PI;
        end else if (zs < -ZPI) begin
          z_nxt = zs + Z2PI;
        end else begin
          z_nxt = zs;
        end
        state_nxt = C_FOLD2;
      end
      C_FOLD2: begin
        if (z_r > ZHP) begin
          z_nxt = ZPI - z_r;
        end else if (z_r < -ZHP) begin
          z_nxt = -ZPI - z_r;
        end
        x_nxt     = XGAIN;
        y_nxt     = '0;
        i_nxt     = '0;
        state_nxt = C_ITER;
      end
      C_ITER: begin
        if (!z_r[CZ_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        if (i_r == LAST_IT) begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    z_r   <= z_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign done    = done_r;
  assign sin_val = 32'(y_r >>> ZSH);

endmodule

// File: rtl/core/pend_alu.sv
module pend_alu (
  input  logic                           clk,
  input  pend_pkg::alu_ctl_t             ctl,
  input  logic signed [31:0]             a,
  input  logic signed [31:0]             b,
  input  logic signed [pend_pkg::ACC_W-1:0] c,
  output logic signed [pend_pkg::ACC_W-1:0] sum_wide,
  output logic signed [31:0]             sum_sat
);
  import pend_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  logic signed [63:0]      prod_r;
  logic signed [63:0]      pn;
  logic signed [63:0]      sh;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= a * b;
    end
  end

  always_comb begin
    pn       = ctl.neg ? -prod_r : prod_r;
    sh       = ctl.stamp_frac ? (pn >>> STAMP_FRAC) : (pn >>> FRAC_BITS);
    sum_wide = ACC_W'(sh) + c;
    if (sum_wide > SAT_HI) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum_wide < SAT_LO) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

endmodule

// File: rtl/core/pendulum_euler_step.sv
// The first tick after reset is accepted and gives no result.
// Each later tick runs from acceptance to out_valid through 5 angle reduction
// steps, 2 fold steps and 30 sine rotations in the CORDIC unit, the done handoff,
// the MUL1/ACC1 to MUL4/ACC4 states on the single shared 32x32 multiplier, then S_PUB.
// No tick is taken before S_PUB ends; a new result while the last one waits holds S_PUB.
// Reset is synchronous and active low; it restores the configuration and step state.
module pendulum_euler_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [47:0]                       in_stamp,
  input  logic signed [31:0]                in_torque,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_angle,
  output logic signed [31:0]                out_rate,
  output logic [47:0]                       out_stamp,
  output logic                              out_finished,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pend_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pend_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pend_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SIN_WAIT = 4'd1;
  localparam logic [3:0] S_MUL1     = 4'd2;
  localparam logic [3:0] S_ACC1     = 4'd3;
  localparam logic [3:0] S_MUL2     = 4'd4;
  localparam logic [3:0] S_ACC2     = 4'd5;
  localparam logic [3:0] S_MUL3     = 4'd6;
  localparam logic [3:0] S_ACC3     = 4'd7;
  localparam logic [3:0] S_MUL4     = 4'd8;
  localparam logic [3:0] S_ACC4     = 4'd9;
  localparam logic [3:0] S_PUB      = 4'd10;

  logic [30:0]        grav_r;
  logic [30:0]        inv_r;
  logic signed [31:0] ctorq_r;
  logic               tsel_r;
  logic [7:0]         pub_r;
  logic [47:0]        stop_r;
  logic signed [31:0] sangle_r;
  logic signed [31:0] srate_r;

  logic [3:0]              state_r, state_nxt;
  logic [47:0]             last_r, last_nxt;
  logic                    have_r, have_nxt;
  logic signed [31:0]      angle_r, angle_nxt;
  logic signed [31:0]      rate_r, rate_nxt;
  logic [7:0]              cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [47:0]             stamp_r, stamp_nxt;
  logic signed [31:0]      dt_r, dt_nxt;
  logic signed [31:0]      torq_r, torq_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0]      accel_r, accel_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [31:0]      oa_r, oa_nxt;
  logic signed [31:0]      or_r, or_nxt;
  logic [47:0]             os_r, os_nxt;
  logic                    of_r, of_nxt;

  logic                    in_acc;
  logic                    cor_start;
  logic                    cor_done;
  logic signed [31:0]      sin_val;
  alu_ctl_t                actl;
  logic signed [31:0]      alu_a;
  logic signed [31:0]      alu_b;
  logic signed [ACC_W-1:0] alu_c;
  logic signed [ACC_W-1:0] sum_wide;
  logic signed [31:0]      sum_sat;
  logic signed [48:0]      diff;
  logic signed [31:0]      dt_sat;
  logic                    emit;
  logic                    fin;
  logic                    out_busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_busy  = ov_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r   <= '0;
      inv_r    <= '0;
      ctorq_r  <= '0;
      tsel_r   <= 1'b0;
      pub_r    <= 8'd2;
      stop_r   <= '0;
      sangle_r <= '0;
      srate_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRAV:        grav_r   <= cfg_data[30:0];
        REG_INV_INERTIA: inv_r    <= cfg_data[30:0];
        REG_CONST_TORQ:  ctorq_r  <= cfg_data[31:0];
        REG_TORQ_SEL:    tsel_r   <= cfg_data[0];
        REG_PUBLISH:     pub_r    <= cfg_data[7:0];
        REG_STOP_TIME:   stop_r   <= cfg_data[47:0];
        REG_START_ANGLE: sangle_r <= cfg_data[31:0];
        REG_START_RATE:  srate_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    diff = $signed({1'b0, in_stamp}) - $signed({1'b0, last_r});
    if (diff > 49'sd2147483647) begin
      dt_sat = 32'sh7FFFFFFF;
    end else if (diff < -49'sd2147483648) begin
      dt_sat = 32'sh80000000;
    end else begin
      dt_sat = diff[31:0];
    end
    fin  = (stop_r != '0) && (stamp_r > stop_r);
    emit = (cnt_r <= 8'd1) || fin;
  end

  always_comb begin
    actl  = '0;
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    unique case (state_r)
      S_MUL1: begin
        actl.mul_en = 1'b1;
        alu_a       = $signed({1'b0, grav_r});
        alu_b       = sin_val;
      end
      S_ACC1: begin
        actl.neg = 1'b1;
      end
      S_MUL2: begin
        actl.mul_en = 1'b1;
        alu_a       = torq_r;
        alu_b       = $signed({1'b0, inv_r});
      end
      S_ACC2: begin
        alu_c = acc_r;
      end
      S_MUL3: begin
        actl.mul_en = 1'b1;
        alu_a       = accel_r;
        alu_b       = dt_r;
      end
      S_ACC3: begin
        actl.stamp_frac = 1'b1;
        alu_c           = ACC_W'(rate_r);
      end
      S_MUL4: begin
        actl.mul_en = 1'b1;
        alu_a       = rate_r;
        alu_b       = dt_r;
      end
      S_ACC4: begin
        actl.stamp_frac = 1'b1;
        alu_c           = ACC_W'(angle_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    have_nxt  = have_r;
    angle_nxt = angle_r;
    rate_nxt  = rate_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    stamp_nxt = stamp_r;
    dt_nxt    = dt_r;
    torq_nxt  = torq_r;
    acc_nxt   = acc_r;
    accel_nxt = accel_r;
    ov_nxt    = ov_r && out_stall;
    oa_nxt    = oa_r;
    or_nxt    = or_r;
    os_nxt    = os_r;
    of_nxt    = of_r;
    cor_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !done_r) begin
          last_nxt = in_stamp;
          if (!have_r) begin
            have_nxt  = 1'b1;
            angle_nxt = sangle_r;
            rate_nxt  = srate_r;
            cnt_nxt   = pub_r;
          end else begin
            stamp_nxt = in_stamp;
            dt_nxt    = dt_sat;
            torq_nxt  = tsel_r ? in_torque : ctorq_r;
            cor_start = 1'b1;
            state_nxt = S_SIN_WAIT;
          end
        end
      end
      S_SIN_WAIT: begin
        if (cor_done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_ACC1;
      S_ACC1: begin
        acc_nxt   = sum_wide;
        state_nxt = S_MUL2;
      end
      S_MUL2: state_nxt = S_ACC2;
      S_ACC2: begin
        accel_nxt = sum_sat;
        state_nxt = S_MUL3;
      end
      S_MUL3: state_nxt = S_ACC3;
      S_ACC3: begin
        rate_nxt  = sum_sat;
        state_nxt = S_MUL4;
      end
      S_MUL4: state_nxt = S_ACC4;
      S_ACC4: begin
        angle_nxt = sum_sat;
        state_nxt = S_PUB;
      end
      S_PUB: begin
        if (!(emit && out_busy)) begin
          cnt_nxt = (cnt_r > 8'd1) ? cnt_r - 8'd1 : pub_r;
          if (fin) begin
            done_nxt = 1'b1;
          end
          if (emit) begin
            ov_nxt = 1'b1;
            oa_nxt = angle_r;
            or_nxt = rate_r;
            os_nxt = stamp_r;
            of_nxt = fin;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= '0;
      have_r  <= 1'b0;
      angle_r <= '0;
      rate_r  <= '0;
      cnt_r   <= 8'd2;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      have_r  <= have_nxt;
      angle_r <= angle_nxt;
      rate_r  <= rate_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
    end
    stamp_r <= stamp_nxt;
    dt_r    <= dt_nxt;
    torq_r  <= torq_nxt;
    acc_r   <= acc_nxt;
    accel_r <= accel_nxt;
    oa_r    <= oa_nxt;
    or_r    <= or_nxt;
    os_r    <= os_nxt;
    of_r    <= of_nxt;
  end

  pend_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (angle_r),
    .done    (cor_done),
    .sin_val (sin_val)
  );

  pend_alu u_alu (
    .clk      (clk),
    .ctl      (actl),
    .a        (alu_a),
    .b        (alu_b),
    .c        (alu_c),
    .sum_wide (sum_wide),
    .sum_sat  (sum_sat)
  );

  assign out_valid    = ov_r;
  assign out_angle    = oa_r;
  assign out_rate     = or_r;
  assign out_stamp    = os_r;
  assign out_finished = of_r;

endmodule

// File: verif/pendulum_euler_step_checker.sv
module pendulum_euler_step_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [47:0]                      in_stamp,
  input  logic signed [31:0]               in_torque,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [31:0]               out_angle,
  input  logic signed [31:0]               out_rate,
  input  logic [47:0]                      out_stamp,
  input  logic                             out_finished,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [pend_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pend_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               errors,
  output int                               waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import pend_pkg::*;

  localparam longint TWO_PI  = longint'(TWO_PI_Q30);
  localparam longint PI      = longint'(PI_Q30);
  localparam longint HALF_PI = longint'(HALF_PI_Q30);
  localparam longint GAIN    = longint'(CORDIC_GAIN_Q30);

  localparam logic [32*30-1:0] ARCTAN_TABLE = {
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002};

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic [47:0]        stamp;
    logic               finished;
  } pend_sample_t;

  logic [30:0]        grav_q;
  logic [30:0]        inv_inertia_q;
  logic signed [31:0] fixed_torque;
  logic               torque_sel;
  logic [7:0]         publish_every_r;
  logic [47:0]        stop_stamp;
  logic signed [31:0] start_angle_r;
  logic signed [31:0] start_rate_r;

  logic [47:0]        last_stamp;
  logic               have_stamp;
  logic               halted;
  longint             angle_q;
  longint             rate_q;
  logic [7:0]         countdown;

  pend_sample_t       expected_samples[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sine_q(input longint ang);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint step_angle;
    z = ang * (64'sd1 << (30 - FRAC_BITS));
    x = GAIN;
    y = 0;
    z = z % TWO_PI;
    if (z > PI) z -= TWO_PI;
    if (z < -PI) z += TWO_PI;
    if (z > HALF_PI) z = PI - z;
    if (z < -HALF_PI) z = -PI - z;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step_angle = longint'(ARCTAN_TABLE[(CORDIC_STEPS - 1 - i)*32 +: 32]);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= step_angle;
      end else begin
        x += dx;
        y -= dy;
        z += step_angle;
      end
    end
    return y >>> (30 - FRAC_BITS);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns result check: %s", $time, msg);
  endtask

  always @(posedge clk) begin : predict_and_compare
    pend_sample_t got;
    pend_sample_t want;
    longint       dt;
    longint       torque;
    longint       accel;
    logic         emit;
    logic         fin;
    if (!rst_n) begin
      grav_q          = '0;
      inv_inertia_q   = '0;
      fixed_torque    = '0;
      torque_sel      = 1'b0;
      publish_every_r = 8'd2;
      stop_stamp      = '0;
      start_angle_r   = '0;
      start_rate_r    = '0;
      last_stamp      = '0;
      have_stamp      = 1'b0;
      halted          = 1'b0;
      angle_q         = 0;
      rate_q          = 0;
      countdown       = 8'd2;
      errors          = 0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.angle    = out_angle;
        got.rate     = out_rate;
        got.stamp    = out_stamp;
        got.finished = out_finished;
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, stamp %h", got.stamp));
        end else begin
          want = expected_samples.pop_front();
          if (got.angle !== want.angle)
            report_mismatch($sformatf("angle %h, expected %h at stamp %h",
                                      got.angle, want.angle, want.stamp));
          if (got.rate !== want.rate)
            report_mismatch($sformatf("rate %h, expected %h at stamp %h",
                                      got.rate, want.rate, want.stamp));
          if (got.stamp !== want.stamp)
            report_mismatch($sformatf("stamp %h, expected %h", got.stamp, want.stamp));
          if (got.finished !== want.finished)
            report_mismatch($sformatf("finished %b, expected %b at stamp %h",
                                      got.finished, want.finished, want.stamp));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAV:        grav_q          = cfg_data[30:0];
          REG_INV_INERTIA: inv_inertia_q   = cfg_data[30:0];
          REG_CONST_TORQ:  fixed_torque    = cfg_data[31:0];
          REG_TORQ_SEL:    torque_sel      = cfg_data[0];
          REG_PUBLISH:     publish_every_r = cfg_data[7:0];
          REG_STOP_TIME:   stop_stamp      = cfg_data[47:0];
          REG_START_ANGLE: start_angle_r   = cfg_data[31:0];
          REG_START_RATE:  start_rate_r    = cfg_data[31:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall && !halted) begin
        if (!have_stamp) begin
          have_stamp = 1'b1;
          last_stamp = in_stamp;
          angle_q    = longint'(start_angle_r);
          rate_q     = longint'(start_rate_r);
          countdown  = publish_every_r;
        end else begin
          dt = clamp32($signed({16'h0, in_stamp}) - $signed({16'h0, last_stamp}));
          last_stamp = in_stamp;
          torque = torque_sel ? longint'(in_torque) : longint'(fixed_torque);
          accel = clamp32(((-(longint'({1'b0, grav_q}) * sine_q(angle_q))) >>> FRAC_BITS)
                          + ((torque * longint'({1'b0, inv_inertia_q})) >>> FRAC_BITS));
          rate_q  = clamp32(rate_q + ((accel * dt) >>> STAMP_FRAC));
          angle_q = clamp32(angle_q + ((rate_q * dt) >>> STAMP_FRAC));
          emit = 1'b0;
          fin  = 1'b0;
          if (countdown > 8'd1) begin
            countdown--;
          end else begin
            emit      = 1'b1;
            countdown = publish_every_r;
          end
          if (stop_stamp != '0 && in_stamp > stop_stamp) begin
            fin    = 1'b1;
            emit   = 1'b1;
            halted = 1'b1;
          end
          if (emit) begin
            want.angle    = angle_q[31:0];
            want.rate     = rate_q[31:0];
            want.stamp    = in_stamp;
            want.finished = fin;
            expected_samples.push_back(want);
          end
        end
      end
    end
    waiting <= expected_samples.size();
  end

endmodule

// File: verif/pendulum_euler_step_tb.sv
module pendulum_euler_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pend_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 20000;
  localparam int BLOCK_ITEMS   = 102;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [47:0]           in_stamp;
  logic signed [31:0]    in_torque;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    out_angle;
  logic signed [31:0]    out_rate;
  logic [47:0]           out_stamp;
  logic                  out_finished;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          errors;
  int          waiting;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles  = 0;
  logic [47:0] prev_stamp    = '0;

  pendulum_euler_step uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_stamp     (in_stamp),
    .in_torque    (in_torque),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_angle    (out_angle),
    .out_rate     (out_rate),
    .out_stamp    (out_stamp),
    .out_finished (out_finished),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pendulum_euler_step_checker result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_stamp     (in_stamp),
    .in_torque    (in_torque),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_angle    (out_angle),
    .out_rate     (out_rate),
    .out_stamp    (out_stamp),
    .out_finished (out_finished),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .waiting      (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pendulum_euler_step_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fills the bits above a register's width with noise; the block must drop them.
  function automatic logic [47:0] pad_junk(input logic [47:0] v, input int w);
    logic [47:0] r;
    r = 48'({$urandom(), $urandom()});
    return (r << w) | v;
  endfunction

  function automatic logic [47:0] pick_stamp(input logic [47:0] prev);
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 78) return prev + 48'($urandom_range(4096, 1));
    if (mode < 86) return prev + 48'($urandom_range(32'h0010_0000, 1));
    if (mode < 92) return prev - 48'($urandom_range(4096, 0));
    if (mode < 97) return 48'({$urandom(), $urandom()});
    return $urandom_range(1) ? '1 : '0;
  endfunction

  function automatic logic [31:0] pick_torque();
    logic [31:0] t;
    int unsigned mode;
    mode = $urandom_range(99);
    t = $urandom();
    if (mode < 65) return {{6{t[25]}}, t[25:0]};
    if (mode < 90) return t;
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [47:0] pick_gain(input logic [31:0] typical_max);
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 12) return '0;
    if (mode < 22) return 48'h7FFF_FFFF;
    return 48'($urandom_range(typical_max));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_tick(input logic [47:0] stamp, input logic [31:0] torque);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_stamp  <= stamp;
    in_torque <= torque;
    do @(posedge clk); while (in_stall);
    prev_stamp = stamp;
  endtask

  // A tick that gives no result may still be in flight when nothing is expected.
  task automatic wait_idle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic randomize_setup();
    int unsigned mode;
    logic [7:0]  every;
    mode = $urandom_range(99);
    if (mode < 70) every = 8'($urandom_range(4, 1));
    else if (mode < 80) every = 8'd0;
    else if (mode < 85) every = 8'd255;
    else every = 8'($urandom_range(255, 1));
    write_reg(REG_GRAV, pad_junk(pick_gain(32'h1000_0000), 31));
    write_reg(REG_INV_INERTIA, pad_junk(pick_gain(32'h0400_0000), 31));
    write_reg(REG_CONST_TORQ, pad_junk({16'h0, pick_torque()}, 32));
    write_reg(REG_TORQ_SEL, pad_junk(48'($urandom_range(1)), 1));
    write_reg(REG_PUBLISH, pad_junk({40'h0, every}, 8));
    write_reg(REG_STOP_TIME, $urandom_range(99) < 60 ? '0 : '1);
    write_reg(REG_START_ANGLE, pad_junk({16'h0, $urandom()}, 32));
    write_reg(REG_START_RATE, pad_junk({16'h0, $urandom()}, 32));
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(15, REG_START_RATE + 1)),
                48'({$urandom(), $urandom()}));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_stamp  <= '0;
    in_torque <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_GRAV, pad_junk(48'd164528357, 31));
    write_reg(REG_INV_INERTIA, pad_junk(48'h0100_0000, 31));
    write_reg(REG_CONST_TORQ, pad_junk(48'hFF80_0000, 32));
    write_reg(REG_TORQ_SEL, pad_junk(48'd0, 1));
    write_reg(REG_PUBLISH, pad_junk(48'd1, 8));
    write_reg(REG_STOP_TIME, '0);
    write_reg(REG_START_ANGLE, pad_junk(48'h8000_0000, 32));
    write_reg(REG_START_RATE, pad_junk(48'h7FFF_FFFF, 32));
    write_reg(REG_UNUSED, '1);

    // The first tick only latches the stamp and the start values.
    send_tick(48'd0, 32'h7FFF_FFFF);
    send_tick(48'd1049, pick_torque());
    send_tick(48'd2098, pick_torque());
    send_tick(48'd3147, pick_torque());
    send_tick(48'd2647, pick_torque());
    send_tick(48'd2647, pick_torque());
    send_tick(48'h0100_0000_0A57, pick_torque());
    send_tick(48'd0, pick_torque());
    send_tick('1, pick_torque());
    send_tick(48'hFFFF_FFFF_F82F, pick_torque());
    wait_idle();

    write_reg(REG_TORQ_SEL, pad_junk(48'd1, 1));
    write_reg(REG_INV_INERTIA, pad_junk(48'h7FFF_FFFF, 31));
    write_reg(REG_GRAV, pad_junk(48'h7FFF_FFFF, 31));
    write_reg(REG_PUBLISH, pad_junk(48'd0, 8));
    send_tick(prev_stamp + 48'd1000, 32'h7FFF_FFFF);
    send_tick(prev_stamp + 48'd1000, 32'h8000_0000);
    send_tick(prev_stamp + 48'd1000, 32'h0000_0000);
    send_tick(prev_stamp + 48'd1000, 32'hFFFF_FFFF);
    send_tick(prev_stamp + 48'd1000, 32'h00C0_0000);
    wait_idle();

    write_reg(REG_GRAV, 48'd0);
    write_reg(REG_INV_INERTIA, 48'd0);
    write_reg(REG_PUBLISH, pad_junk(48'd255, 8));
    write_reg(REG_STOP_TIME, '1);
    repeat (4) send_tick(prev_stamp + 48'd1049, pick_torque());

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 52;
        end
        default: begin
          send_idle_pct = 26;
          recv_idle_pct = 26;
        end
      endcase
      repeat (4) begin
        wait_idle();
        randomize_setup();
        repeat (BLOCK_ITEMS) send_tick(pick_stamp(prev_stamp), pick_torque());
      end
    end

    // The tick equal to the stop time still runs; the next one ends the run and
    // every later tick is dropped.
    wait_idle();
    write_reg(REG_STOP_TIME, '0);
    send_tick(48'h1000_0000, pick_torque());
    wait_idle();
    write_reg(REG_STOP_TIME, 48'h1000_0000 + 48'd3000);
    write_reg(REG_PUBLISH, pad_junk(48'd4, 8));
    for (int k = 1; k <= 6; k++) send_tick(48'h1000_0000 + 48'(1000 * k), pick_torque());
    wait_idle();

    if (errors == 0 && waiting == 0) begin
      $display("pendulum_euler_step_tb: PASS");
    end else begin
      $display("pendulum_euler_step_tb: FAIL");
    end
    $finish;
  end

endmodule
